@@ hw/rtl/pad_input_edge_autorepeat_unit_defines.svh @@
// Assertion macros for the controller frame edge detector
`ifndef PAD_INPUT_EDGE_AUTOREPEAT_UNIT_DEFINES_SVH
`define PAD_INPUT_EDGE_AUTOREPEAT_UNIT_DEFINES_SVH

// Check a property on every rising edge outside reset
`define PIEA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("pad input edge autorepeat: check failed");

// Check that a condition never holds outside reset
`define PIEA_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("pad input edge autorepeat: forbidden condition");

`endif

@@ hw/rtl/piea_pkg.sv @@
package piea_pkg;

  localparam int unsigned NUM_BUTTONS_DEF    = 16;
  localparam int unsigned NUM_STICK_DIRS_DEF = 8;
  localparam int unsigned COUNT_WIDTH_DEF    = 16;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_START    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_INTERVAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STICK_THRESHOLD = 2'd2;

  localparam logic [15:0] REPEAT_START_RST    = 16'd30;
  localparam logic [15:0] REPEAT_INTERVAL_RST = 16'd5;
  localparam logic [14:0] STICK_THRESHOLD_RST = 15'd16384;

  localparam logic [7:0] TRIGGER_LEVEL = 8'd127;

  localparam int unsigned IN_W    = 96;
  localparam int unsigned MASK_W  = 26;
  localparam int unsigned REP_W   = 24;
  localparam int unsigned FIRST_W = 5;
  localparam int unsigned OUT_W   = 112;

  localparam int unsigned HELD_LSB  = 0;
  localparam int unsigned PRESS_LSB = HELD_LSB + MASK_W;
  localparam int unsigned REL_LSB   = PRESS_LSB + MASK_W;
  localparam int unsigned REP_LSB   = REL_LSB + MASK_W;
  localparam int unsigned FIRST_LSB = REP_LSB + REP_W;
  localparam int unsigned ANY_BIT   = FIRST_LSB + FIRST_W;

endpackage

@@ hw/rtl/pad_input_edge_autorepeat_unit.sv @@
// Channel   Direction  Handshake                       Payload
// s_axis    in         s_axis_tvalid / s_axis_tready   s_axis_tdata, one controller frame
// m_axis    out        m_axis_tvalid / m_axis_tready   m_axis_tdata, one result item
// cfg       in         cfg_we_i, no back-pressure      cfg_idx_i, cfg_wdata_i
//
// One item at a time; each counter is read (S_READ) and then updated (S_CALC), and a counter
// past repeat_start also runs the remainder unit (S_DIV) before the sweep moves on.
// The single memory port sets the sweep.
// Reset clears control and per-entry counter valid bits; configuration takes reset values.
// A result waiting on m_axis does not block the next item; the sweep stalls at its end.
module pad_input_edge_autorepeat_unit #(
  parameter int unsigned NUM_BUTTONS    = piea_pkg::NUM_BUTTONS_DEF,
  parameter int unsigned NUM_STICK_DIRS = piea_pkg::NUM_STICK_DIRS_DEF,
  parameter int unsigned COUNT_WIDTH    = piea_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [piea_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [piea_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // button_bits, left_x, left_y, right_x, right_y, left_trigger, right_trigger
  input  logic [piea_pkg::IN_W-1:0]       s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // held_mask, pressed_mask, released_mask, repeat_mask, first_active, any_active, pad
  output logic [piea_pkg::OUT_W-1:0]      m_axis_tdata
);

  localparam int unsigned NumCounted = NUM_BUTTONS + NUM_STICK_DIRS;
  localparam int unsigned NumBits    = NumCounted + 2;
  localparam int unsigned IdxW       = (NumCounted > 1) ? $clog2(NumCounted) : 1;
  localparam int unsigned CmpW       = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
  localparam int unsigned DivCntW    = $clog2(CmpW);
  localparam int unsigned MaskW      = piea_pkg::MASK_W;
  localparam int unsigned RepW       = piea_pkg::REP_W;
  localparam int unsigned FirstW     = piea_pkg::FIRST_W;
  localparam int unsigned PadW       = piea_pkg::OUT_W - piea_pkg::ANY_BIT - 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_CALC = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]                  state_q, state_d;
  logic [IdxW-1:0]             idx_q, idx_d;
  logic [NumCounted-1:0]       vld_q, vld_d;
  logic [NumBits-1:0]          cur_q, cur_d;
  logic [NumBits-1:0]          prev_q, prev_d;
  logic                        out_valid_q, out_valid_d;
  logic [15:0]                 rep_start_q;
  logic [15:0]                 rep_interval_q;
  logic [14:0]                 stick_thr_q;

  logic [NumCounted-1:0]       rep_q, rep_d;
  logic [CmpW-1:0]             div_rem_q, div_rem_d;
  logic [CmpW-1:0]             div_x_q, div_x_d;
  logic [DivCntW-1:0]          div_cnt_q, div_cnt_d;
  logic [piea_pkg::OUT_W-1:0]  out_data_q, out_data_d;

  logic [COUNT_WIDTH-1:0]      cnt_mem [NumCounted];
  logic [COUNT_WIDTH-1:0]      rd_q;

  logic [15:0]                 button_bits;
  logic signed [15:0]          left_x, left_y, right_x, right_y;
  logic [7:0]                  left_trigger, right_trigger;

  logic [14:0]                 thr;
  logic signed [16:0]          thr_pos, thr_neg;
  logic [7:0]                  dirs;
  logic [31:0]                 btn_masked;
  logic [7:0]                  dirs_masked;
  logic [1:0]                  trig;
  logic [NumBits-1:0]          vec;

  logic [COUNT_WIDTH-1:0]      cnt_rd, cnt_new;
  logic                        act;
  logic [CmpW-1:0]             cnt_ext, start_ext, iv_ext;
  logic [15:0]                 iv;
  logic [CmpW:0]               trial;
  logic                        trial_ge;
  logic [CmpW-1:0]             rem_nxt;
  logic                        last_idx;

  logic [NumBits+MaskW-1:0]    held_ext, press_ext, rel_ext;
  logic [NumCounted+RepW-1:0]  rep_ext;
  logic [FirstW-1:0]           first_idx;
  logic                        any_act;

  assign button_bits   = s_axis_tdata[15:0];
  assign left_x        = s_axis_tdata[31:16];
  assign left_y        = s_axis_tdata[47:32];
  assign right_x       = s_axis_tdata[63:48];
  assign right_y       = s_axis_tdata[79:64];
  assign left_trigger  = s_axis_tdata[87:80];
  assign right_trigger = s_axis_tdata[95:88];

  assign thr     = (stick_thr_q == '0) ? 15'd1 : stick_thr_q;
  assign thr_pos = $signed({2'b00, thr});
  assign thr_neg = 17'sd0 - thr_pos;

  always_comb begin
    dirs[0] = $signed({left_y[15], left_y})   >= thr_pos;
    dirs[1] = $signed({left_y[15], left_y})   <= thr_neg;
    dirs[2] = $signed({left_x[15], left_x})   >= thr_pos;
    dirs[3] = $signed({left_x[15], left_x})   <= thr_neg;
    dirs[4] = $signed({right_y[15], right_y}) >= thr_pos;
    dirs[5] = $signed({right_y[15], right_y}) <= thr_neg;
    dirs[6] = $signed({right_x[15], right_x}) >= thr_pos;
    dirs[7] = $signed({right_x[15], right_x}) <= thr_neg;
  end

  assign btn_masked  = {16'b0, button_bits} & 32'((64'd1 << NUM_BUTTONS) - 64'd1);
  assign dirs_masked = dirs & 8'((16'd1 << NUM_STICK_DIRS) - 16'd1);
  assign trig        = {right_trigger > piea_pkg::TRIGGER_LEVEL,
                        left_trigger > piea_pkg::TRIGGER_LEVEL};
  assign vec         = NumBits'(btn_masked)
                     | (NumBits'(dirs_masked) << NUM_BUTTONS)
                     | (NumBits'(trig) << NumCounted);

  assign cnt_rd   = vld_q[idx_q] ? rd_q : '0;
  assign act      = cur_q[idx_q];
  assign cnt_new  = !act ? '0 : ((&cnt_rd) ? cnt_rd : cnt_rd + 1'b1);
  assign cnt_ext  = CmpW'(cnt_new);
  assign start_ext = CmpW'(rep_start_q);
  assign iv       = (rep_interval_q == '0) ? 16'd1 : rep_interval_q;
  assign iv_ext   = CmpW'(iv);
  assign last_idx = (idx_q == IdxW'(NumCounted - 1));

  assign trial    = {div_rem_q, div_x_q[CmpW-1]};
  assign trial_ge = trial >= {1'b0, iv_ext};
  assign rem_nxt  = trial_ge ? CmpW'(trial - {1'b0, iv_ext}) : trial[CmpW-1:0];

  assign held_ext  = {{MaskW{1'b0}}, cur_q};
  assign press_ext = {{MaskW{1'b0}}, cur_q & ~prev_q};
  assign rel_ext   = {{MaskW{1'b0}}, prev_q & ~cur_q};
  assign rep_ext   = {{RepW{1'b0}}, rep_q};
  assign any_act   = |cur_q;

  always_comb begin
    first_idx = '0;
    for (int i = NumBits - 1; i >= 0; i--) begin
      if (cur_q[i]) begin
        first_idx = FirstW'(i);
      end
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    vld_d       = vld_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    out_valid_d = out_valid_q;
    rep_d       = rep_q;
    div_rem_d   = div_rem_q;
    div_x_d     = div_x_q;
    div_cnt_d   = div_cnt_q;
    out_data_d  = out_data_q;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          prev_d  = cur_q;
          cur_d   = vec;
          rep_d   = '0;
          idx_d   = '0;
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_CALC;
      end
      S_CALC: begin
        vld_d[idx_q] = 1'b1;
        if (cnt_ext > start_ext) begin
          div_rem_d = '0;
          div_x_d   = cnt_ext - start_ext;
          div_cnt_d = '0;
          state_d   = S_DIV;
        end else begin
          rep_d[idx_q] = (cnt_new == COUNT_WIDTH'(1));
          if (last_idx) begin
            state_d = S_DONE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_READ;
          end
        end
      end
      S_DIV: begin
        div_rem_d = rem_nxt;
        div_x_d   = div_x_q << 1;
        div_cnt_d = div_cnt_q + 1'b1;
        if (div_cnt_q == DivCntW'(CmpW - 1)) begin
          rep_d[idx_q] = (rem_nxt == '0);
          if (last_idx) begin
            state_d = S_DONE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_READ;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_data_d  = {{PadW{1'b0}}, any_act, first_idx, rep_ext[RepW-1:0],
                         rel_ext[MaskW-1:0], press_ext[MaskW-1:0], held_ext[MaskW-1:0]};
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      idx_q          <= '0;
      vld_q          <= '0;
      cur_q          <= '0;
      prev_q         <= '0;
      out_valid_q    <= 1'b0;
      rep_start_q    <= piea_pkg::REPEAT_START_RST;
      rep_interval_q <= piea_pkg::REPEAT_INTERVAL_RST;
      stick_thr_q    <= piea_pkg::STICK_THRESHOLD_RST;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      vld_q       <= vld_d;
      cur_q       <= cur_d;
      prev_q      <= prev_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          piea_pkg::REG_REPEAT_START:    rep_start_q    <= cfg_wdata_i;
          piea_pkg::REG_REPEAT_INTERVAL: rep_interval_q <= cfg_wdata_i;
          piea_pkg::REG_STICK_THRESHOLD: stick_thr_q    <= cfg_wdata_i[14:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rep_q      <= rep_d;
    div_rem_q  <= div_rem_d;
    div_x_q    <= div_x_d;
    div_cnt_q  <= div_cnt_d;
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_CALC) begin
      cnt_mem[idx_q] <= cnt_new;
    end
    if (state_q == S_READ) begin
      rd_q <= cnt_mem[idx_q];
    end
  end

endmodule

@@ hw/rtl/piea_checker.sv @@
`include "pad_input_edge_autorepeat_unit_defines.svh"

module piea_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [piea_pkg::OUT_W-1:0]      m_axis_tdata
);

  logic [piea_pkg::MASK_W-1:0]  held, pressed, released;
  logic [piea_pkg::REP_W-1:0]   rep;
  logic [piea_pkg::FIRST_W-1:0] first;
  logic                         any;
  logic [piea_pkg::MASK_W-1:0]  below_first;

  assign held     = m_axis_tdata[piea_pkg::HELD_LSB +: piea_pkg::MASK_W];
  assign pressed  = m_axis_tdata[piea_pkg::PRESS_LSB +: piea_pkg::MASK_W];
  assign released = m_axis_tdata[piea_pkg::REL_LSB +: piea_pkg::MASK_W];
  assign rep      = m_axis_tdata[piea_pkg::REP_LSB +: piea_pkg::REP_W];
  assign first    = m_axis_tdata[piea_pkg::FIRST_LSB +: piea_pkg::FIRST_W];
  assign any      = m_axis_tdata[piea_pkg::ANY_BIT];
  assign below_first = held & ((piea_pkg::MASK_W'(1) << first) - 1'b1);

  // hold a stalled result
  `PIEA_ASSERT(a_out_hold, clk_i, rst_ni,
               m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))

  // edges and repeat pulses agree with the held mask
  `PIEA_ASSERT_NEVER(a_mask_consistent, clk_i, rst_ni,
                     m_axis_tvalid && (((pressed & ~held) != '0) || ((released & held) != '0)
                     || ((rep & ~held[piea_pkg::REP_W-1:0]) != '0)))

  // lowest active index and activity flag match the held mask
  `PIEA_ASSERT(a_first_active, clk_i, rst_ni,
               m_axis_tvalid |-> (any == (held != '0))
               && (!any || (held[first] && (below_first == '0))))

  // drop ready after taking an item
  `PIEA_ASSERT(a_one_item, clk_i, rst_ni,
               s_axis_tvalid && s_axis_tready |=> !s_axis_tready)

endmodule

bind pad_input_edge_autorepeat_unit piea_checker u_piea_checker (.*);
